// ===== sv/ddp_pkg.sv =====
package ddp_pkg;

    localparam int unsigned FRACTION_DIGITS_DEF = 7;

    localparam logic [2:0] PH_START  = 3'd0;
    localparam logic [2:0] PH_SIGNED = 3'd1;
    localparam logic [2:0] PH_INT    = 3'd2;
    localparam logic [2:0] PH_FRAC   = 3'd3;
    localparam logic [2:0] PH_SKIP   = 3'd4;
    localparam logic [2:0] PH_BAD    = 3'd5;

    localparam logic [7:0] CHAR_MINUS  = 8'h2D;
    localparam logic [7:0] CHAR_POINT  = 8'h2E;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_NINE   = 8'h39;

    localparam logic [7:0]  MAX_WHOLE  = 8'd181;
    localparam logic [31:0] DEG_SCALE  = 32'd10000000;

    typedef struct packed {
        logic [2:0]  phase;
        logic        neg;
        logic [7:0]  whole;
        logic [23:0] frac;
        logic [2:0]  count;
    } t_parse_state;

    localparam t_parse_state PARSE_CLEAR = '{
        phase: PH_START, neg: 1'b0, whole: 8'd0, frac: 24'd0, count: 3'd0
    };

    // weight of the fraction digit at a given position after the point
    function automatic logic [23:0] digit_weight(input logic [2:0] pos);
        logic [23:0] w;
        case (pos)
            3'd0:    w = 24'd1000000;
            3'd1:    w = 24'd100000;
            3'd2:    w = 24'd10000;
            3'd3:    w = 24'd1000;
            3'd4:    w = 24'd100;
            3'd5:    w = 24'd10;
            3'd6:    w = 24'd1;
            default: w = 24'd0;
        endcase
        return w;
    endfunction

endpackage

// ===== sv/ddp_char_step.sv =====
module ddp_char_step
    import ddp_pkg::*;
#(
    parameter int unsigned FRACTION_DIGITS = FRACTION_DIGITS_DEF
) (
    input  t_parse_state i_state,
    input  logic [7:0]   i_char_code,
    input  logic         i_char_present,
    output t_parse_state o_state
);

    localparam logic [2:0] MAX_COUNT = 3'(FRACTION_DIGITS);

    logic        is_digit;
    logic [3:0]  digit;
    logic [11:0] whole_wide;
    logic [7:0]  whole_sat;
    logic [27:0] frac_term;

    assign is_digit   = (i_char_code >= CHAR_ZERO) && (i_char_code <= CHAR_NINE);
    assign digit      = i_char_code[3:0];
    assign whole_wide = {4'd0, i_state.whole} * 12'd10 + {8'd0, digit};
    assign whole_sat  = (whole_wide > 12'd255) ? 8'd255 : whole_wide[7:0];
    assign frac_term  = {24'd0, digit} * {4'd0, digit_weight(i_state.count)};

    always_comb begin
        o_state = i_state;
        if (i_char_present) begin
            case (i_state.phase)
                PH_START: begin
                    if (i_char_code == CHAR_MINUS) begin
                        o_state.neg   = 1'b1;
                        o_state.phase = PH_SIGNED;
                    end else if (is_digit) begin
                        o_state.whole = whole_sat;
                        o_state.phase = PH_INT;
                    end else begin
                        o_state.phase = PH_BAD;
                    end
                end
                PH_SIGNED: begin
                    if (is_digit) begin
                        o_state.whole = whole_sat;
                        o_state.phase = PH_INT;
                    end else begin
                        o_state.phase = PH_BAD;
                    end
                end
                PH_INT: begin
                    if (is_digit) begin
                        o_state.whole = whole_sat;
                    end else if (i_char_code == CHAR_POINT) begin
                        o_state.phase = PH_FRAC;
                    end else begin
                        o_state.phase = PH_BAD;
                    end
                end
                PH_FRAC: begin
                    if (is_digit && (i_state.count < MAX_COUNT)) begin
                        o_state.frac  = i_state.frac + frac_term[23:0];
                        o_state.count = i_state.count + 3'd1;
                    end else begin
                        o_state.phase = PH_SKIP;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== sv/decimal_degrees_parser_core.sv =====
// decimal degrees parser
// input channel: one ASCII character of a latitude or longitude field per word
// (i_char_code, qualified by i_char_present), i_field_end marks the last word
// of the field; a word with only i_field_end set closes the field bare
// output channel: one word per field, o_degrees_scaled is signed degrees
// times 10^7, o_bad_value flags a malformed field or whole degrees above 181
// (value then reads 0)
// throughput: one input word per cycle while o_ready is high; the parse
// state update and the final scale-and-add are a single registered pass
// latency: the result is valid in the cycle after its field-end word is taken
// a result held by a stalled receiver keeps o_ready low only until i_ready
// returns; with i_ready high the input side never stops
// reset clears the parse state to the start of a field and drops o_valid
module decimal_degrees_parser_core
    import ddp_pkg::*;
#(
    parameter int unsigned FRACTION_DIGITS = FRACTION_DIGITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_char_code,
    input  logic               i_char_present,
    input  logic               i_field_end,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_degrees_scaled,
    output logic               o_bad_value
);

    t_parse_state r_state, n_state, step_state;
    logic         r_out_valid;
    logic [31:0]  r_value;
    logic         r_bad;
    logic         accept;
    logic         field_bad;
    logic [31:0]  mag;

    ddp_char_step #(
        .FRACTION_DIGITS(FRACTION_DIGITS)
    ) u_step (
        .i_state        (r_state),
        .i_char_code    (i_char_code),
        .i_char_present (i_char_present),
        .o_state        (step_state)
    );

    assign o_ready = !r_out_valid || i_ready;
    assign accept  = i_valid && o_ready;

    assign field_bad = !((step_state.phase == PH_FRAC) || (step_state.phase == PH_SKIP))
                       || (step_state.whole > MAX_WHOLE);
    assign mag = {24'd0, step_state.whole} * DEG_SCALE + {8'd0, step_state.frac};

    always_comb begin
        n_state = r_state;
        if (accept) begin
            n_state = i_field_end ? PARSE_CLEAR : step_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= PARSE_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept && i_field_end) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_field_end) begin
            r_bad   <= field_bad;
            r_value <= field_bad ? 32'd0 : (step_state.neg ? (32'd0 - mag) : mag);
        end
    end

    assign o_valid          = r_out_valid;
    assign o_degrees_scaled = $signed(r_value);
    assign o_bad_value      = r_bad;

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_value |-> o_degrees_scaled == 32'sd0)
        else $error("bad result with nonzero value");

    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_field_end |=> o_valid)
        else $error("field end produced no result");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_field_end |=> r_state.phase == PH_START && r_state.whole == 8'd0
            && r_state.frac == 24'd0 && !r_state.neg)
        else $error("parse state not cleared after field end");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_bad_value |-> o_degrees_scaled <= 32'sd1819999999
            && o_degrees_scaled >= -32'sd1819999999)
        else $error("result out of range");

endmodule
